/* rtl/rpwb_pkg.sv */
// shared types, constants and helpers for the raw pixel white balance block
// no dependencies
package rpwb_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [SAMPLE_W-1:0] CLAMP_MAX  = 16'hFFFE;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'h1000;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]   t_gain;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONO_MODE     = 3'd0,
        CFG_WIDE_SAMPLES  = 3'd1,
        CFG_MOSAIC_ENABLE = 3'd2,
        CFG_GAIN_0        = 3'd3,
        CFG_GAIN_1        = 3'd4,
        CFG_GAIN_2        = 3'd5,
        CFG_GAIN_3        = 3'd6
    } t_cfg_idx;

    // memory byte order to sample value: narrow samples sit in the upper byte
    function automatic t_sample unpack_sample(input logic [15:0] raw, input logic wide);
        t_sample res;
        if (wide) begin
            res = {raw[7:0], raw[15:8]};
        end else begin
            res = {raw[7:0], 8'h00};
        end
        return res;
    endfunction

endpackage

/* rtl/rpwb_chan.sv */
// one color channel: q4.12 gain multiply, truncate and clamp, or bypass
// depends on rpwb_pkg
module rpwb_chan
    import rpwb_pkg::*;
(
    input  t_sample i_sample,
    input  t_gain   i_gain,
    input  logic    i_bypass,
    output t_sample o_value
);

    logic [SAMPLE_W+GAIN_W-1:0]           prod;
    logic [SAMPLE_W+GAIN_W-FRAC_BITS-1:0] scaled;

    assign prod   = {{GAIN_W{1'b0}}, i_sample} * {{SAMPLE_W{1'b0}}, i_gain};
    assign scaled = prod[SAMPLE_W+GAIN_W-1:FRAC_BITS];

    always_comb begin
        priority if (i_bypass) begin
            o_value = i_sample;
        end else if (scaled > {{(GAIN_W-FRAC_BITS){1'b0}}, CLAMP_MAX}) begin
            o_value = CLAMP_MAX;
        end else begin
            o_value = scaled[SAMPLE_W-1:0];
        end
    end

endmodule

/* rtl/raw_pixel_white_balance_top.sv */
// raw pixel white balance: a pixel passes the stage 1 and stage 2 registers;
// one pixel per cycle unless stalled; stage 1 unpacks and selects gains, stage 2
// holds the three multiply-and-clamp results (one 16x16 multiplier per channel)
// synchronous active-low reset clears the valid bits, the column parity and
// the config registers (modes off, all gains 1.0)
module raw_pixel_white_balance_top
    import rpwb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [15:0]          i_raw_first,
    input  logic [15:0]          i_raw_second,
    input  logic [15:0]          i_raw_third,
    input  logic                 i_row_odd,
    input  logic                 i_row_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_out_first,
    output logic [15:0]          o_out_second,
    output logic [15:0]          o_out_third,
    output logic                 o_out_row_end
);

    logic  r_mono_mode;
    logic  r_wide_samples;
    logic  r_mosaic_enable;
    t_gain r_gain [4];
    logic  r_column_odd;

    logic    r_s1_vld;
    t_sample r_s1_sample [3];
    t_gain   r_s1_gain   [3];
    logic    r_s1_bypass;
    logic    r_s1_row_end;

    logic    r_out_vld;
    t_sample r_out_value [3];
    logic    r_out_row_end;

    logic    out_adv;
    logic    s1_adv;
    logic    in_xfer;
    t_gain   n_gain [3];
    t_sample chan_value [3];

    assign out_adv = !r_out_vld || !i_stall;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_stall = !s1_adv;
    assign in_xfer = i_valid && s1_adv;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_mode     <= 1'b0;
            r_wide_samples  <= 1'b0;
            r_mosaic_enable <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_gain[i] <= GAIN_RESET;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MONO_MODE:     r_mono_mode     <= i_cfg_wdata[0];
                CFG_WIDE_SAMPLES:  r_wide_samples  <= i_cfg_wdata[0];
                CFG_MOSAIC_ENABLE: r_mosaic_enable <= i_cfg_wdata[0];
                CFG_GAIN_0:        r_gain[0]       <= i_cfg_wdata;
                CFG_GAIN_1:        r_gain[1]       <= i_cfg_wdata;
                CFG_GAIN_2:        r_gain[2]       <= i_cfg_wdata;
                CFG_GAIN_3:        r_gain[3]       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // gain per channel; mono zeroes the unused channels through a zero gain
    always_comb begin
        if (r_mono_mode) begin
            n_gain[0] = r_gain[{i_row_odd, r_column_odd}];
            n_gain[1] = '0;
            n_gain[2] = '0;
        end else begin
            n_gain[0] = r_gain[0];
            n_gain[1] = r_gain[1];
            n_gain[2] = r_gain[2];
        end
    end

    // column parity, advanced on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_odd <= 1'b0;
        end else if (in_xfer) begin
            r_column_odd <= i_row_end ? 1'b0 : !r_column_odd;
        end
    end

    // stage 1: unpacked samples and selected gains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_sample[0] <= unpack_sample(i_raw_first, r_wide_samples);
            r_s1_sample[1] <= unpack_sample(i_raw_second, r_wide_samples);
            r_s1_sample[2] <= unpack_sample(i_raw_third, r_wide_samples);
            r_s1_gain[0]   <= n_gain[0];
            r_s1_gain[1]   <= n_gain[1];
            r_s1_gain[2]   <= n_gain[2];
            r_s1_bypass    <= r_mono_mode && !r_mosaic_enable;
            r_s1_row_end   <= i_row_end;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        rpwb_chan u_chan (
            .i_sample (r_s1_sample[c]),
            .i_gain   (r_s1_gain[c]),
            .i_bypass ((c == 0) ? r_s1_bypass : 1'b0),
            .o_value  (chan_value[c])
        );
    end

    // stage 2: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && out_adv) begin
            r_out_value[0] <= chan_value[0];
            r_out_value[1] <= chan_value[1];
            r_out_value[2] <= chan_value[2];
            r_out_row_end  <= r_s1_row_end;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_out_first   = r_out_value[0];
    assign o_out_second  = r_out_value[1];
    assign o_out_third   = r_out_value[2];
    assign o_out_row_end = r_out_row_end;

endmodule

/* rtl/rpwb_checker.sv */
// port-level checks for raw_pixel_white_balance_top, bound to the top level
// no dependencies
module rpwb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_out_first,
    input logic [15:0] o_out_second,
    input logic [15:0] o_out_third,
    input logic        o_out_row_end
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_first) && $stable(o_out_second)
            && $stable(o_out_third) && $stable(o_out_row_end))
        else $error("result changed while stalled");

    // input side only backs up when the output side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room downstream");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind raw_pixel_white_balance_top rpwb_checker u_rpwb_checker (.*);

/* sim/rpwb_checker.sv */
`timescale 1ns / 100ps
// result checker for raw_pixel_white_balance_top: predicts each corrected pixel from
// the input transfers and register writes and compares it with the output transfers
// depends on rtl/rpwb_pkg.sv
module rpwb_result_checker
    import rpwb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [15:0]          i_raw_first,
    input  logic [15:0]          i_raw_second,
    input  logic [15:0]          i_raw_third,
    input  logic                 i_row_odd,
    input  logic                 i_row_end,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [15:0]          i_out_first,
    input  logic [15:0]          i_out_second,
    input  logic [15:0]          i_out_third,
    input  logic                 i_out_row_end,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_sample first;
        t_sample second;
        t_sample third;
        logic    row_end;
    } t_pixel_result;

    // register copies and column parity as the block should hold them
    logic  mono_q;
    logic  wide_q;
    logic  mosaic_q;
    t_gain gain_q [4];
    logic  column_odd_q;

    t_pixel_result corrected_q [$];
    int            fail_total  = 0;
    int            queue_depth = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = queue_depth;

    // multiply by a Q4.12 gain, drop the fraction and saturate
    function automatic t_sample apply_wb_gain(input logic [15:0] raw, input t_gain gain);
        logic [15:0] value;
        logic [31:0] prod;
        value = wide_q ? {raw[7:0], raw[15:8]} : {raw[7:0], 8'h00};
        prod  = (32'(value) * 32'(gain)) >> FRAC_BITS;
        if (prod > 32'(CLAMP_MAX)) begin
            return CLAMP_MAX;
        end
        return prod[15:0];
    endfunction

    function automatic t_pixel_result balance_pixel(input logic [15:0] r1,
                                                    input logic [15:0] r2,
                                                    input logic [15:0] r3,
                                                    input logic        row_odd,
                                                    input logic        row_end);
        t_pixel_result res;
        res = '0;
        res.row_end = row_end;
        if (mono_q) begin
            if (mosaic_q) begin
                res.first = apply_wb_gain(r1, gain_q[{row_odd, column_odd_q}]);
            end else begin
                // plain pass-through, no clamp
                res.first = unpack_sample(r1, wide_q);
            end
        end else begin
            res.first  = apply_wb_gain(r1, gain_q[0]);
            res.second = apply_wb_gain(r2, gain_q[1]);
            res.third  = apply_wb_gain(r3, gain_q[2]);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            mono_q       = 1'b0;
            wide_q       = 1'b0;
            mosaic_q     = 1'b0;
            gain_q       = '{GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET};
            column_odd_q = 1'b0;
            corrected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (corrected_q.size() == 0) begin
                    $error("result transfer with no pixel outstanding");
                    fail_total++;
                end else begin
                    want = corrected_q.pop_front();
                    if (i_out_first !== want.first) begin
                        $error("out_first: expected %h, got %h", want.first, i_out_first);
                        fail_total++;
                    end
                    if (i_out_second !== want.second) begin
                        $error("out_second: expected %h, got %h", want.second, i_out_second);
                        fail_total++;
                    end
                    if (i_out_third !== want.third) begin
                        $error("out_third: expected %h, got %h", want.third, i_out_third);
                        fail_total++;
                    end
                    if (i_out_row_end !== want.row_end) begin
                        $error("out_row_end: expected %b, got %b", want.row_end,
                               i_out_row_end);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MONO_MODE:     mono_q    = i_cfg_wdata[0];
                    CFG_WIDE_SAMPLES:  wide_q    = i_cfg_wdata[0];
                    CFG_MOSAIC_ENABLE: mosaic_q  = i_cfg_wdata[0];
                    CFG_GAIN_0:        gain_q[0] = i_cfg_wdata;
                    CFG_GAIN_1:        gain_q[1] = i_cfg_wdata;
                    CFG_GAIN_2:        gain_q[2] = i_cfg_wdata;
                    CFG_GAIN_3:        gain_q[3] = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                corrected_q.push_back(balance_pixel(i_raw_first, i_raw_second,
                                                    i_raw_third, i_row_odd, i_row_end));
                column_odd_q = i_row_end ? 1'b0 : ~column_odd_q;
            end
        end
        queue_depth = corrected_q.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// top of the white balance testbench: clock, reset, register writes, pixel stimulus
// and verdict; depends on rtl/rpwb_pkg.sv, the block's rtl and sim/rpwb_checker.sv
module testbench;
    import rpwb_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [15:0]          i_cfg_wdata  = '0;
    logic                 i_valid      = 1'b0;
    logic [15:0]          i_raw_first  = '0;
    logic [15:0]          i_raw_second = '0;
    logic [15:0]          i_raw_third  = '0;
    logic                 i_row_odd    = 1'b0;
    logic                 i_row_end    = 1'b0;
    logic                 i_stall      = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [15:0]          o_out_first;
    logic [15:0]          o_out_second;
    logic [15:0]          o_out_third;
    logic                 o_out_row_end;

    int   fail_count;
    int   pixels_pending;
    logic tx_throttle = 1'b0;
    logic rx_throttle = 1'b0;
    int   stall_left  = 0;

    raw_pixel_white_balance_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_raw_first   (i_raw_first),
        .i_raw_second  (i_raw_second),
        .i_raw_third   (i_raw_third),
        .i_row_odd     (i_row_odd),
        .i_row_end     (i_row_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_first   (o_out_first),
        .o_out_second  (o_out_second),
        .o_out_third   (o_out_third),
        .o_out_row_end (o_out_row_end)
    );

    rpwb_result_checker u_result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_raw_first   (i_raw_first),
        .i_raw_second  (i_raw_second),
        .i_raw_third   (i_raw_third),
        .i_row_odd     (i_row_odd),
        .i_row_end     (i_row_end),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_first   (o_out_first),
        .i_out_second  (o_out_second),
        .i_out_third   (o_out_third),
        .i_out_row_end (o_out_row_end),
        .o_fail_count  (fail_count),
        .o_pending     (pixels_pending)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // output back-pressure in bursts, mostly short
    always @(negedge i_clk) begin
        if (stall_left == 0 && rx_throttle && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 3);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!tx_throttle || roll < 65) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return GAIN_RESET;
            3:       return 16'($urandom_range(16'h0800, 16'h2000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input logic [15:0] r1, input logic [15:0] r2,
                              input logic [15:0] r3, input logic row_odd,
                              input logic row_end);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_raw_first  <= r1;
        i_raw_second <= r2;
        i_raw_third  <= r3;
        i_row_odd    <= row_odd;
        i_row_end    <= row_end;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and let every outstanding pixel come out
    task automatic drain_pixels();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pixels_pending == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_random_config(input int phase);
        write_reg(CFG_MONO_MODE, 16'($urandom));
        write_reg(CFG_WIDE_SAMPLES, 16'($urandom));
        write_reg(CFG_MOSAIC_ENABLE, 16'($urandom));
        if (phase == 0) begin
            write_reg(CFG_GAIN_0, 16'hFFFF);
            write_reg(CFG_GAIN_1, 16'hFFFF);
            write_reg(CFG_GAIN_2, 16'hFFFF);
            write_reg(CFG_GAIN_3, 16'hFFFF);
        end else if (phase == 1) begin
            write_reg(CFG_GAIN_0, 16'h0000);
            write_reg(CFG_GAIN_1, 16'h0000);
            write_reg(CFG_GAIN_2, 16'h0000);
            write_reg(CFG_GAIN_3, 16'h0000);
        end else begin
            write_reg(CFG_GAIN_0, pick_gain());
            write_reg(CFG_GAIN_1, pick_gain());
            write_reg(CFG_GAIN_2, pick_gain());
            write_reg(CFG_GAIN_3, pick_gain());
        end
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_UNUSED_IDX, 16'($urandom));
        end
    endtask

    // rows of random length with alternating parity, plus some stray markers
    task automatic stream_rows(input int count);
        int   left_in_row;
        logic row_par;
        logic ro;
        logic re;
        left_in_row = $urandom_range(1, 12);
        row_par     = 1'b0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                ro = 1'($urandom);
                re = 1'($urandom);
            end else begin
                left_in_row--;
                ro = row_par;
                re = (left_in_row == 0);
                if (re) begin
                    row_par     = ~row_par;
                    left_in_row = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64)
                                                              : $urandom_range(1, 12);
                end
            end
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom), ro, re);
            if ($urandom_range(0, 199) == 0) begin
                drain_pixels();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: colour, narrow samples, unity gains
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_pixel(16'h00FF, 16'hFF00, 16'h5A80, 1'b1, 1'b1);

        // wide samples, saturating, zero and unity gains
        drain_pixels();
        write_reg(CFG_WIDE_SAMPLES, 16'hFFFF);
        write_reg(CFG_GAIN_0, 16'hFFFF);
        write_reg(CFG_GAIN_1, 16'h0000);
        write_reg(CFG_GAIN_2, GAIN_RESET);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_pixel(16'h0001, 16'h8001, 16'hFEFF, 1'b0, 1'b0);
        send_pixel(16'h3412, 16'hCDAB, 16'h0000, 1'b0, 1'b1);

        // mono bayer sites, and a write to the unused index that must do nothing
        drain_pixels();
        write_reg(CFG_MONO_MODE, 16'h0001);
        write_reg(CFG_MOSAIC_ENABLE, 16'h0001);
        write_reg(CFG_GAIN_0, 16'h0800);
        write_reg(CFG_GAIN_1, 16'h1800);
        write_reg(CFG_GAIN_2, 16'h2000);
        write_reg(CFG_GAIN_3, 16'h0C00);
        write_reg(CFG_UNUSED_IDX, 16'h0000);
        send_pixel(16'h4080, 16'h1111, 16'h2222, 1'b0, 1'b0);
        send_pixel(16'h4080, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_pixel(16'h00C0, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_pixel(16'h8070, 16'h0000, 16'h0000, 1'b1, 1'b0);
        send_pixel(16'h8070, 16'h0000, 16'h0000, 1'b1, 1'b1);

        // mono pass-through, narrow; row left open across the next writes
        drain_pixels();
        write_reg(CFG_MOSAIC_ENABLE, 16'hFFFE);
        write_reg(CFG_WIDE_SAMPLES, 16'h0000);
        send_pixel(16'hA5FF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_pixel(16'h5A00, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_pixel(16'hFF7F, 16'h0000, 16'h0000, 1'b0, 1'b0);

        // mid-row write: column parity carries on
        drain_pixels();
        write_reg(CFG_MOSAIC_ENABLE, 16'h0001);
        send_pixel(16'h00FF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_pixel(16'h00FF, 16'h0000, 16'h0000, 1'b0, 1'b1);

        for (int phase = 0; phase < 9; phase++) begin
            drain_pixels();
            load_random_config(phase);
            tx_throttle = (phase != 2) && ($urandom_range(0, 3) != 0);
            rx_throttle = (phase != 2) && ($urandom_range(0, 3) != 0);
            stream_rows(150);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pixels_pending == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
